### design/bddfs_pkg.sv
// Shared types and constants for the display frame sequencer.
package bddfs_pkg;

  typedef enum logic [1:0] {
    ACT_INIT   = 2'd0,
    ACT_NUMBER = 2'd1,
    ACT_DASH   = 2'd2,
    ACT_BLANK  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    CFG_DIGIT_BASE  = 2'd0,
    CFG_DECODE_MODE = 2'd1,
    CFG_INTENSITY   = 2'd2,
    CFG_SCAN_LIMIT  = 2'd3
  } cfg_index_e;

  // controller register addresses
  localparam logic [3:0] ADDR_DECODE    = 4'h9;
  localparam logic [3:0] ADDR_INTENSITY = 4'hA;
  localparam logic [3:0] ADDR_SCANLIMIT = 4'hB;
  localparam logic [3:0] ADDR_SHUTDOWN  = 4'hC;
  localparam logic [3:0] ADDR_TEST      = 4'hF;

  localparam logic [7:0] CODE_DASH  = 8'h0A;
  localparam logic [7:0] CODE_BLANK = 8'h0F;

  localparam int ValueW          = 16;
  localparam int NumBcd          = 5;  // 16-bit value fits in five decimal digits
  localparam int MaxFrames       = 6;
  localparam int InitFrames      = 6;
  localparam int QueueDepth      = 2;
  localparam int DdStepsPerCycle = 4;
  localparam int DdCycles        = ValueW / DdStepsPerCycle;

  typedef logic [NumBcd-1:0][3:0] bcd_t;

  typedef struct packed {
    action_e action;
    bcd_t    bcd;
  } cmd_t;

  typedef struct packed {
    logic [2:0] digit_base;
    logic [7:0] decode_mode;
    logic [3:0] intensity;
    logic [2:0] scan_limit;
  } cfg_t;

endpackage

### design/bcd_digit_display_frame_sequencer.sv
// Top level: config registers, command intake, queue and frame generator.
// A start passes the queue, then the generator's active and strobe registers; show number converts to BCD first.
// Throughput: one frame per cycle; show number occupies intake while the BCD unit converts it.
// Intake accepts a new word while frames of earlier words are still going out (2-deep queue).
// Frames cannot be stalled: strobe_o marks each word for exactly one cycle.
// Reset: queue empty, no strobe, config registers take base 0, decode 255, intensity 8, scan 7.
module bcd_digit_display_frame_sequencer #(
  parameter int NUM_DIGITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [15:0] value_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output logic        strobe_o,
  output logic [3:0]  reg_address_o,
  output logic [7:0]  reg_data_o,
  output logic        last_o
);
  import bddfs_pkg::*;

  cfg_t  cfg_q;
  logic  push;
  logic  full;
  logic  pop;
  logic  q_valid;
  cmd_t  front_cmd;
  cmd_t  queue_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.digit_base  <= 3'd0;
      cfg_q.decode_mode <= 8'd255;
      cfg_q.intensity   <= 4'd8;
      cfg_q.scan_limit  <= 3'd7;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_DIGIT_BASE:  cfg_q.digit_base  <= cfg_data_i[2:0];
        CFG_DECODE_MODE: cfg_q.decode_mode <= cfg_data_i;
        CFG_INTENSITY:   cfg_q.intensity   <= cfg_data_i[3:0];
        CFG_SCAN_LIMIT:  cfg_q.scan_limit  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  bddfs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .action_i (action_i),
    .value_i  (value_i),
    .full_i   (full),
    .push_o   (push),
    .cmd_o    (front_cmd)
  );

  bddfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (queue_cmd)
  );

  bddfs_back #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .cmd_i         (queue_cmd),
    .pop_o         (pop),
    .strobe_o      (strobe_o),
    .reg_address_o (reg_address_o),
    .reg_data_o    (reg_data_o),
    .last_o        (last_o)
  );

endmodule

### design/bddfs_front.sv
// Command intake: accepts commands and converts show-number values to BCD.
module bddfs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        action_i,
  input  logic [15:0]       value_i,
  input  logic              full_i,
  output logic              push_o,
  output bddfs_pkg::cmd_t   cmd_o
);
  import bddfs_pkg::*;

  localparam int CntW = $clog2(DdCycles);

  front_state_e       state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [ValueW-1:0]  bin_q, bin_d;
  bcd_t               bcd_q, bcd_d;
  logic               accept;
  logic               load;

  assign busy   = (state_q != FE_IDLE) | full_i;
  assign accept = start & ~busy;

  // double dabble, several shift steps per cycle
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    for (int s = 0; s < DdStepsPerCycle; s++) begin
      for (int d = 0; d < NumBcd; d++) begin
        if (bcd_d[d] >= 4'd5) bcd_d[d] = bcd_d[d] + 4'd3;
      end
      {bcd_d, bin_d} = {bcd_d, bin_d} << 1;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    load    = 1'b0;
    push_o  = 1'b0;
    cmd_o   = '{action: action_e'(action_i), bcd: '0};
    unique case (state_q)
      FE_IDLE: begin
        if (accept) begin
          if (action_e'(action_i) == ACT_NUMBER) begin
            load    = 1'b1;
            cnt_d   = '0;
            state_d = FE_CONV;
          end else begin
            push_o = 1'b1;
          end
        end
      end
      FE_CONV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DdCycles - 1)) state_d = FE_PUSH;
      end
      FE_PUSH: begin
        cmd_o = '{action: ACT_NUMBER, bcd: bcd_q};
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FE_IDLE;
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (state_q == FE_CONV) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

endmodule

### design/bddfs_queue.sv
// Short command queue between intake and frame generation.
module bddfs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bddfs_pkg::cmd_t   cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output bddfs_pkg::cmd_t   cmd_o
);
  import bddfs_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t             mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");

endmodule

### design/bddfs_back.sv
// Frame generator: walks each queued command and emits one register word per cycle.
module bddfs_back #(
  parameter int NUM_DIGITS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bddfs_pkg::cfg_t   cfg_i,
  input  logic              q_valid_i,
  input  bddfs_pkg::cmd_t   cmd_i,
  output logic              pop_o,
  output logic              strobe_o,
  output logic [3:0]        reg_address_o,
  output logic [7:0]        reg_data_o,
  output logic              last_o
);
  import bddfs_pkg::*;

  localparam int NFrames = (NUM_DIGITS > MaxFrames) ? MaxFrames :
                           ((NUM_DIGITS < 1) ? 1 : NUM_DIGITS);
  localparam logic [3:0] MaxBase = 4'(8 - NFrames);

  cmd_t        cur_q;
  logic        active_q;
  logic [2:0]  idx_q;
  logic [2:0]  last_idx;
  logic        frame_last;
  logic [3:0]  base;
  logic [3:0]  pos;
  logic [2:0]  dsel;
  logic [3:0]  addr_d;
  logic [7:0]  data_d;
  logic        strobe_q;
  logic [3:0]  addr_q;
  logic [7:0]  data_q;
  logic        last_q;

  assign base = ({1'b0, cfg_i.digit_base} > MaxBase) ? MaxBase : {1'b0, cfg_i.digit_base};

  assign last_idx   = (cur_q.action == ACT_INIT) ? 3'(InitFrames - 1) : 3'(NFrames - 1);
  assign frame_last = active_q && (idx_q == last_idx);
  assign pop_o      = q_valid_i && (!active_q || frame_last);

  // number frames run from the top digit position down
  assign pos  = 4'(NFrames) - {1'b0, idx_q};
  assign dsel = 3'(pos - 4'd1);

  always_comb begin
    addr_d = ADDR_TEST;
    data_d = '0;
    unique case (cur_q.action)
      ACT_INIT: begin
        case (idx_q)
          3'd0: begin addr_d = ADDR_SHUTDOWN;  data_d = 8'd1; end
          3'd1: begin addr_d = ADDR_DECODE;    data_d = cfg_i.decode_mode; end
          3'd2: begin addr_d = ADDR_INTENSITY; data_d = {4'b0, cfg_i.intensity}; end
          3'd3: begin addr_d = ADDR_SCANLIMIT; data_d = {5'b0, cfg_i.scan_limit}; end
          3'd4: begin addr_d = ADDR_TEST;      data_d = 8'd1; end
          default: begin addr_d = ADDR_TEST;   data_d = 8'd0; end
        endcase
      end
      ACT_NUMBER: begin
        addr_d = base + pos;
        data_d = (dsel < 3'(NumBcd)) ? {4'b0, cur_q.bcd[dsel]} : 8'd0;
      end
      ACT_DASH: begin
        addr_d = base + {1'b0, idx_q} + 4'd1;
        data_d = CODE_DASH;
      end
      ACT_BLANK: begin
        addr_d = base + {1'b0, idx_q} + 4'd1;
        data_d = CODE_BLANK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= active_q;
      if (pop_o) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (frame_last) begin
        active_q <= 1'b0;
      end else if (active_q) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= cmd_i;
    if (active_q) begin
      addr_q <= addr_d;
      data_q <= data_d;
      last_q <= frame_last;
    end
  end

  assign strobe_o      = strobe_q;
  assign reg_address_o = addr_q;
  assign reg_data_o    = data_q;
  assign last_o        = last_q;

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> idx_q <= last_idx)
    else $error("frame index past end of command");

  a_frames_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && !last_q |=> strobe_q)
    else $error("gap inside a command's frames");

  a_addr_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> (addr_q >= 4'd1 && addr_q <= 4'd8) || addr_q == ADDR_DECODE ||
                 addr_q == ADDR_INTENSITY || addr_q == ADDR_SCANLIMIT ||
                 addr_q == ADDR_SHUTDOWN || addr_q == ADDR_TEST)
    else $error("frame to unexpected register address");

endmodule
